@@ src/rdz_pkg.sv @@
// ----------------------------------------------------------------------------
// rdz_pkg
// Shared constants, register codes and pipeline sideband types for the
// radial dead zone stick block.
// ----------------------------------------------------------------------------
package rdz_pkg;

  localparam int AXIS_BITS_DEF        = 16;
  localparam int LENGTH_FRAC_BITS_DEF = 8;

  localparam int MAG_BITS       = 16;
  localparam int OUT_BITS       = 16;
  localparam int QUOT_BITS      = 16;
  localparam int DZ_BITS        = 15;
  localparam int FS_BITS        = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [DZ_BITS-1:0]  DEAD_ZONE_RST  = 15'd8000;
  localparam logic [FS_BITS-1:0]  FULL_SCALE_RST = 16'd30000;
  localparam logic [OUT_BITS-1:0] Q15_MAX        = 16'd32767;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEAD_ZONE  = 2'd0,
    REG_FULL_SCALE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                valid;
    logic                sx;
    logic                sy;
    logic [MAG_BITS-1:0] mag_x;
    logic [MAG_BITS-1:0] mag_y;
  } stick_side_t;

  typedef struct packed {
    logic valid;
    logic sx;
    logic sy;
    logic kill;
    logic active;
  } div_side_t;

endpackage

@@ src/rdz_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rdz_sqrt_cell
// One bit of a pipelined restoring square root: tries one root bit and
// hands the remainder, partial root and sideband to the next cell.
// ----------------------------------------------------------------------------
module rdz_sqrt_cell #(
  parameter int ROOT_BITS = 24,
  parameter int BIT_POS   = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [2*ROOT_BITS-1:0]  rem_in,
  input  logic [ROOT_BITS-1:0]    root_in,
  input  rdz_pkg::stick_side_t    side_in,
  output logic [2*ROOT_BITS-1:0]  rem_out,
  output logic [ROOT_BITS-1:0]    root_out,
  output rdz_pkg::stick_side_t    side_out
);
  import rdz_pkg::*;

  localparam int RW = 2 * ROOT_BITS + 1;

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_ext;
  logic          take;

  assign rem_ext = RW'(rem_in);
  assign trial   = (RW'(root_in) << (BIT_POS + 1)) + (RW'(1) << (2 * BIT_POS));
  assign take    = rem_ext >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    side_out.sx    <= side_in.sx;
    side_out.sy    <= side_in.sy;
    side_out.mag_x <= side_in.mag_x;
    side_out.mag_y <= side_in.mag_y;
    if (take) begin
      rem_out  <= (2*ROOT_BITS)'(rem_ext - trial);
      root_out <= root_in | (ROOT_BITS'(1) << BIT_POS);
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in;
    end
  end

endmodule

@@ src/rdz_div_cell.sv @@
// ----------------------------------------------------------------------------
// rdz_div_cell
// One quotient bit of a pipelined restoring divider, both axes sharing one
// divisor; passes remainders, quotients and divisor to the next cell.
// ----------------------------------------------------------------------------
module rdz_div_cell #(
  parameter int REM_BITS = 56,
  parameter int DEN_BITS = 40,
  parameter int BIT_POS  = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [REM_BITS-1:0]           rem_x_in,
  input  logic [REM_BITS-1:0]           rem_y_in,
  input  logic [rdz_pkg::QUOT_BITS-1:0] q_x_in,
  input  logic [rdz_pkg::QUOT_BITS-1:0] q_y_in,
  input  logic [DEN_BITS-1:0]           den_in,
  input  rdz_pkg::div_side_t            side_in,
  output logic [REM_BITS-1:0]           rem_x_out,
  output logic [REM_BITS-1:0]           rem_y_out,
  output logic [rdz_pkg::QUOT_BITS-1:0] q_x_out,
  output logic [rdz_pkg::QUOT_BITS-1:0] q_y_out,
  output logic [DEN_BITS-1:0]           den_out,
  output rdz_pkg::div_side_t            side_out
);
  import rdz_pkg::*;

  logic [REM_BITS-1:0] den_sh;
  logic                take_x;
  logic                take_y;

  assign den_sh = REM_BITS'(den_in) << BIT_POS;
  assign take_x = rem_x_in >= den_sh;
  assign take_y = rem_y_in >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    side_out.sx     <= side_in.sx;
    side_out.sy     <= side_in.sy;
    side_out.kill   <= side_in.kill;
    side_out.active <= side_in.active;
    den_out         <= den_in;
    rem_x_out       <= take_x ? rem_x_in - den_sh : rem_x_in;
    rem_y_out       <= take_y ? rem_y_in - den_sh : rem_y_in;
    q_x_out         <= q_x_in | (take_x ? QUOT_BITS'(1) << BIT_POS : '0);
    q_y_out         <= q_y_in | (take_y ? QUOT_BITS'(1) << BIT_POS : '0);
  end

endmodule

@@ src/radial_dead_zone_stick_top.sv @@
// ----------------------------------------------------------------------------
// radial_dead_zone_stick_top
// Scaled radial dead zone for one analog stick sample.
//
// Usage: drive axis_x/axis_y with start high; a sample is taken at every
// clock edge with start high and busy low. busy stays low, so a new sample
// may be taken every cycle. One result per sample appears on stick_x,
// stick_y and active with done high for exactly one cycle, in sample order.
// The pipeline holds, in order, these registered stages:
// input and square stages, one cell per root bit of the square root chain,
// two stages of span and multiply, sixteen divider cells, one output stage.
// Throughput is one sample per cycle; each chain cell holds one sample.
// The receiver cannot stall; results are dropped if not taken.
// Reset (rst, synchronous) empties the pipeline and loads dead_zone 8000
// and full_scale 30000. Register writes on cfg_we/cfg_index/cfg_data take
// effect at once and belong between bursts while the pipeline is empty.
// ----------------------------------------------------------------------------
module radial_dead_zone_stick_top #(
  parameter int AXIS_BITS        = rdz_pkg::AXIS_BITS_DEF,
  parameter int LENGTH_FRAC_BITS = rdz_pkg::LENGTH_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [15:0]                axis_x,
  input  logic signed [15:0]                axis_y,
  output logic                              done,
  output logic signed [15:0]                stick_x,
  output logic signed [15:0]                stick_y,
  output logic                              active,
  input  logic                              cfg_we,
  input  logic [rdz_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rdz_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import rdz_pkg::*;

  localparam int AB  = AXIS_BITS;
  localparam int F   = LENGTH_FRAC_BITS;
  localparam int RB  = AB + F;
  localparam int LW  = MAG_BITS + 1 + F;
  localparam int MW  = FS_BITS + F;
  localparam int AW  = MAG_BITS + MW;
  localparam int DW  = FS_BITS + RB;
  localparam int PW  = AW + QUOT_BITS;
  localparam int LAT = RB + 21;

  logic [DZ_BITS-1:0] dead_zone;
  logic [FS_BITS-1:0] full_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone  <= DEAD_ZONE_RST;
      full_scale <= FULL_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEAD_ZONE:  dead_zone  <= cfg_data[DZ_BITS-1:0];
        REG_FULL_SCALE: full_scale <= cfg_data[FS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: magnitudes and signs
  logic [AB:0]  ext_x, ext_y, neg_x, neg_y;
  stick_side_t  side_a;

  assign ext_x = {axis_x[AB-1], axis_x[AB-1:0]};
  assign ext_y = {axis_y[AB-1], axis_y[AB-1:0]};
  assign neg_x = -ext_x;
  assign neg_y = -ext_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.valid <= 1'b0;
    end else begin
      side_a.valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    side_a.sx    <= axis_x[AB-1];
    side_a.sy    <= axis_y[AB-1];
    side_a.mag_x <= MAG_BITS'(axis_x[AB-1] ? neg_x[AB-1:0] : ext_x[AB-1:0]);
    side_a.mag_y <= MAG_BITS'(axis_y[AB-1] ? neg_y[AB-1:0] : ext_y[AB-1:0]);
  end

  // squares
  logic [2*RB-1:0] rad [RB+1];
  logic [RB-1:0]   root [RB+1];
  stick_side_t     sside [RB+1];
  logic [2*AB-1:0] sq_x, sq_y;

  assign sq_x = (2*AB)'(side_a.mag_x[AB-1:0] * side_a.mag_x[AB-1:0]);
  assign sq_y = (2*AB)'(side_a.mag_y[AB-1:0] * side_a.mag_y[AB-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sside[0].valid <= 1'b0;
    end else begin
      sside[0].valid <= side_a.valid;
    end
  end

  always_ff @(posedge clk) begin
    sside[0].sx    <= side_a.sx;
    sside[0].sy    <= side_a.sy;
    sside[0].mag_x <= side_a.mag_x;
    sside[0].mag_y <= side_a.mag_y;
    rad[0]         <= (2*RB)'(sq_x + sq_y) << (2 * F);
    root[0]        <= '0;
  end

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    rdz_sqrt_cell #(
      .ROOT_BITS (RB),
      .BIT_POS   (RB - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .rem_in   (rad[i]),
      .root_in  (root[i]),
      .side_in  (sside[i]),
      .rem_out  (rad[i+1]),
      .root_out (root[i+1]),
      .side_out (sside[i+1])
    );
  end

  // span stage
  logic [LW-1:0]      lq_e, dzq, diff, cap;
  logic [FS_BITS-1:0] span;
  logic               fs_le, centered;
  logic [MW-1:0]      m_c;
  logic [FS_BITS-1:0] s_c;
  stick_side_t        side_c;
  logic [RB-1:0]      lq_c;
  logic [MW-1:0]      m_r;
  logic [FS_BITS-1:0] s_r;
  logic               kill_c, active_c;

  assign lq_e     = LW'(root[RB]);
  assign dzq      = LW'(dead_zone) << F;
  assign centered = lq_e < dzq;
  assign diff     = lq_e - dzq;
  assign fs_le    = full_scale <= FS_BITS'(dead_zone);
  assign span     = full_scale - FS_BITS'(dead_zone);
  assign cap      = LW'(span) << F;
  assign m_c      = fs_le ? MW'(1) << F : MW'((diff > cap) ? cap : diff);
  assign s_c      = fs_le ? FS_BITS'(1) : span;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_c.valid <= 1'b0;
    end else begin
      side_c.valid <= sside[RB].valid;
    end
  end

  always_ff @(posedge clk) begin
    side_c.sx    <= sside[RB].sx;
    side_c.sy    <= sside[RB].sy;
    side_c.mag_x <= sside[RB].mag_x;
    side_c.mag_y <= sside[RB].mag_y;
    lq_c         <= root[RB];
    m_r          <= m_c;
    s_r          <= s_c;
    kill_c       <= centered | (root[RB] == '0);
    active_c     <= ~centered;
  end

  // multiply stage
  logic [PW-1:0]  rem_x [QUOT_BITS+1];
  logic [PW-1:0]  rem_y [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_x [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_y [QUOT_BITS+1];
  logic [DW-1:0]  den [QUOT_BITS+1];
  div_side_t      dside [QUOT_BITS+1];
  logic [AW-1:0]  prod_x, prod_y;

  assign prod_x = AW'(side_c.mag_x * m_r);
  assign prod_y = AW'(side_c.mag_y * m_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      dside[0].valid <= 1'b0;
    end else begin
      dside[0].valid <= side_c.valid;
    end
  end

  always_ff @(posedge clk) begin
    dside[0].sx     <= side_c.sx;
    dside[0].sy     <= side_c.sy;
    dside[0].kill   <= kill_c;
    dside[0].active <= active_c;
    rem_x[0]        <= PW'(prod_x) << (QUOT_BITS - 1);
    rem_y[0]        <= PW'(prod_y) << (QUOT_BITS - 1);
    q_x[0]          <= '0;
    q_y[0]          <= '0;
    den[0]          <= DW'(s_r * lq_c);
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    rdz_div_cell #(
      .REM_BITS (PW),
      .DEN_BITS (DW),
      .BIT_POS  (QUOT_BITS - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .rem_x_in  (rem_x[k]),
      .rem_y_in  (rem_y[k]),
      .q_x_in    (q_x[k]),
      .q_y_in    (q_y[k]),
      .den_in    (den[k]),
      .side_in   (dside[k]),
      .rem_x_out (rem_x[k+1]),
      .rem_y_out (rem_y[k+1]),
      .q_x_out   (q_x[k+1]),
      .q_y_out   (q_y[k+1]),
      .den_out   (den[k+1]),
      .side_out  (dside[k+1])
    );
  end

  // output stage: saturate and restore sign
  div_side_t           dlast;
  logic [OUT_BITS-1:0] mag_x, mag_y;

  assign dlast = dside[QUOT_BITS];
  assign mag_x = dlast.kill ? '0 :
                 (q_x[QUOT_BITS][QUOT_BITS-1] ? Q15_MAX : OUT_BITS'(q_x[QUOT_BITS]));
  assign mag_y = dlast.kill ? '0 :
                 (q_y[QUOT_BITS][QUOT_BITS-1] ? Q15_MAX : OUT_BITS'(q_y[QUOT_BITS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dlast.valid;
    end
  end

  always_ff @(posedge clk) begin
    stick_x <= dlast.sx ? -mag_x : mag_x;
    stick_y <= dlast.sy ? -mag_y : mag_y;
    active  <= dlast.active;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a transfer at the expected latency");

  a_centered_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !active) |-> (stick_x == '0 && stick_y == '0))
    else $error("centered sample with nonzero output");

  a_no_min : assert property (@(posedge clk) disable iff (rst)
    done |-> (stick_x != 16'sh8000 && stick_y != 16'sh8000))
    else $error("output outside saturation range");

endmodule
